### src/hrhp_pkg.sv
// Shared types and constants of the HTTP request header parser.
package hrhp_pkg;

   localparam int unsigned DefMaxMethodLen = 7;
   localparam int unsigned DefMaxUriLen = 255;
   localparam int unsigned DefMaxVersionLen = 9;
   localparam int unsigned DefMaxHostLen = 255;
   localparam int unsigned DefMaxTypeLen = 50;
   localparam int unsigned DefMaxLengthDigits = 10;

   localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NL = 8'h0A;

   typedef enum logic [2:0] {
      FLD_METHOD  = 3'd0,
      FLD_URI     = 3'd1,
      FLD_VERSION = 3'd2,
      FLD_HOST    = 3'd3,
      FLD_TYPE    = 3'd4,
      FLD_BODY    = 3'd5,
      FLD_SUMMARY = 3'd6
   } field_type;

   typedef enum logic [8:0] {
      PH_METHOD  = 9'b000000001,
      PH_URI     = 9'b000000010,
      PH_VERSION = 9'b000000100,
      PH_HNAME   = 9'b000001000,
      PH_SKIP    = 9'b000010000,
      PH_HOSTV   = 9'b000100000,
      PH_LENV    = 9'b001000000,
      PH_TYPEV   = 9'b010000000,
      PH_BODY    = 9'b100000000
   } phase_type;

   // One queue entry: up to two results from one input byte.
   typedef struct packed {
      logic        tok_vld;
      field_type   tok_field;
      logic [7:0]  tok_byte;
      logic        sum_vld;
      logic        sum_valid;
      logic [30:0] length;
   } work_type;

   // Result with its last flag.
   typedef struct packed {
      field_type   field;
      logic [7:0]  data;
      logic [30:0] length;
      logic        valid;
      logic        last;
   } rsp_type;

   function automatic logic [7:0] host_char(input logic [4:0] pos);
      case (pos)
         5'd0: host_char = "H";
         5'd1: host_char = "o";
         5'd2: host_char = "s";
         5'd3: host_char = "t";
         5'd4: host_char = ":";
         5'd5: host_char = " ";
         default: host_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] clen_char(input logic [4:0] pos);
      case (pos)
         5'd0: clen_char = "C";
         5'd1: clen_char = "o";
         5'd2: clen_char = "n";
         5'd3: clen_char = "t";
         5'd4: clen_char = "e";
         5'd5: clen_char = "n";
         5'd6: clen_char = "t";
         5'd7: clen_char = "-";
         5'd8: clen_char = "L";
         5'd9: clen_char = "e";
         5'd10: clen_char = "n";
         5'd11: clen_char = "g";
         5'd12: clen_char = "t";
         5'd13: clen_char = "h";
         5'd14: clen_char = ":";
         5'd15: clen_char = " ";
         default: clen_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] ctype_char(input logic [4:0] pos);
      case (pos)
         5'd0: ctype_char = "C";
         5'd1: ctype_char = "o";
         5'd2: ctype_char = "n";
         5'd3: ctype_char = "t";
         5'd4: ctype_char = "e";
         5'd5: ctype_char = "n";
         5'd6: ctype_char = "t";
         5'd7: ctype_char = "-";
         5'd8: ctype_char = "T";
         5'd9: ctype_char = "y";
         5'd10: ctype_char = "p";
         5'd11: ctype_char = "e";
         5'd12: ctype_char = ":";
         5'd13: ctype_char = " ";
         default: ctype_char = 8'h00;
      endcase
   endfunction

endpackage

### src/hrhp_front.sv
// Front end: parses each request byte and forms the results it causes.
module hrhp_front
   import hrhp_pkg::*;
#(
   parameter int unsigned MAX_METHOD_LEN = DefMaxMethodLen,
   parameter int unsigned MAX_URI_LEN = DefMaxUriLen,
   parameter int unsigned MAX_VERSION_LEN = DefMaxVersionLen,
   parameter int unsigned MAX_HOST_LEN = DefMaxHostLen,
   parameter int unsigned MAX_TYPE_LEN = DefMaxTypeLen,
   parameter int unsigned MAX_LENGTH_DIGITS = DefMaxLengthDigits
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_vld,
   input  logic [7:0] in_byte,
   input  logic       in_end,
   output logic       wr_en,
   output work_type   wr_data
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  tcnt_ff, tcnt_in;
   logic [4:0]  npos_ff, npos_in;
   logic [2:0]  hcand_ff, hcand_in;
   logic [1:0]  mcand_ff, mcand_in;
   logic        host_ff, host_in;
   logic [30:0] len_ff, len_in;
   logic [30:0] body_ff, body_in;
   logic        pnl_ff, pnl_in;

   logic        sep, nl, is_digit;
   logic [2:0]  hc;
   logic [4:0]  npos_nx;
   logic [7:0]  tcnt_sat;
   logic [34:0] len_mul;
   logic [3:0]  digit;

   assign nl = (in_byte == CH_NL);
   assign sep = nl || (in_byte == CH_SPACE);
   assign is_digit = (in_byte >= "0") && (in_byte <= "9");
   assign digit = in_byte[3:0];
   assign tcnt_sat = (tcnt_ff == 8'd255) ? tcnt_ff : tcnt_ff + 8'd1;
   // len*10 = len*8 + len*2; fits 35 bits.
   assign len_mul = {1'b0, len_ff, 3'b000} + {3'b000, len_ff, 1'b0} + {31'd0, digit};
   assign npos_nx = npos_ff + 5'd1;

   always_comb begin
      hc[0] = hcand_ff[0] && (npos_ff < 5'd6) && (in_byte == host_char(npos_ff));
      hc[1] = hcand_ff[1] && (npos_ff < 5'd16) && (in_byte == clen_char(npos_ff));
      hc[2] = hcand_ff[2] && (npos_ff < 5'd14) && (in_byte == ctype_char(npos_ff));
   end

   always_comb begin
      phase_in = phase_ff;
      tcnt_in = tcnt_ff;
      npos_in = npos_ff;
      hcand_in = hcand_ff;
      mcand_in = mcand_ff;
      host_in = host_ff;
      len_in = len_ff;
      body_in = body_ff;
      pnl_in = nl;
      wr_data = '0;
      wr_data.tok_field = FLD_METHOD;
      unique case (phase_ff)
         PH_METHOD: begin
            if (sep) begin
               if (tcnt_ff != 8'd3) mcand_in[0] = 1'b0;
               if (tcnt_ff != 8'd4) mcand_in[1] = 1'b0;
               phase_in = PH_URI;
               tcnt_in = '0;
            end else begin
               case (tcnt_ff)
                  8'd0: begin
                     if (in_byte != "G") mcand_in[0] = 1'b0;
                     if (in_byte != "P") mcand_in[1] = 1'b0;
                  end
                  8'd1: begin
                     if (in_byte != "E") mcand_in[0] = 1'b0;
                     if (in_byte != "O") mcand_in[1] = 1'b0;
                  end
                  8'd2: begin
                     if (in_byte != "T") mcand_in[0] = 1'b0;
                     if (in_byte != "S") mcand_in[1] = 1'b0;
                  end
                  8'd3: begin
                     mcand_in[0] = 1'b0;
                     if (in_byte != "T") mcand_in[1] = 1'b0;
                  end
                  default: mcand_in = 2'b00;
               endcase
               wr_data.tok_vld = (32'(tcnt_ff) < MAX_METHOD_LEN);
               wr_data.tok_field = FLD_METHOD;
               tcnt_in = tcnt_sat;
            end
         end
         PH_URI: begin
            if (sep) begin
               phase_in = PH_VERSION;
               tcnt_in = '0;
            end else begin
               wr_data.tok_vld = (32'(tcnt_ff) < MAX_URI_LEN);
               wr_data.tok_field = FLD_URI;
               tcnt_in = tcnt_sat;
            end
         end
         PH_VERSION: begin
            if (nl) begin
               phase_in = PH_HNAME; npos_in = '0; hcand_in = 3'b111;
            end else if (sep) begin
               phase_in = PH_SKIP;
            end else begin
               wr_data.tok_vld = (32'(tcnt_ff) < MAX_VERSION_LEN);
               wr_data.tok_field = FLD_VERSION;
               tcnt_in = tcnt_sat;
            end
         end
         PH_SKIP: begin
            if (nl) begin
               phase_in = PH_HNAME; npos_in = '0; hcand_in = 3'b111;
            end
         end
         PH_HNAME: begin
            if (nl) begin
               if (npos_ff == '0 && pnl_ff) begin
                  phase_in = PH_BODY;
                  body_in = '0;
               end else begin
                  phase_in = PH_HNAME; npos_in = '0; hcand_in = 3'b111;
               end
            end else if (hc == 3'b000) begin
               phase_in = PH_SKIP;
               npos_in = '0;
               hcand_in = hc;
            end else begin
               hcand_in = hc;
               npos_in = npos_nx;
               if (hc[0] && npos_nx == 5'd6) begin
                  tcnt_in = '0; npos_in = '0; hcand_in = 3'b111;
                  phase_in = PH_HOSTV; host_in = 1'b1;
               end else if (hc[1] && npos_nx == 5'd16) begin
                  tcnt_in = '0; npos_in = '0; hcand_in = 3'b111;
                  phase_in = PH_LENV; len_in = '0;
               end else if (hc[2] && npos_nx == 5'd14) begin
                  tcnt_in = '0; npos_in = '0; hcand_in = 3'b111;
                  phase_in = PH_TYPEV;
               end
            end
         end
         PH_HOSTV, PH_TYPEV: begin
            if (nl) begin
               phase_in = PH_HNAME; npos_in = '0; hcand_in = 3'b111;
            end else if (sep) begin
               phase_in = PH_SKIP;
            end else begin
               if (phase_ff == PH_HOSTV) begin
                  wr_data.tok_vld = (32'(tcnt_ff) < MAX_HOST_LEN);
                  wr_data.tok_field = FLD_HOST;
               end else begin
                  wr_data.tok_vld = (32'(tcnt_ff) < MAX_TYPE_LEN);
                  wr_data.tok_field = FLD_TYPE;
               end
               tcnt_in = tcnt_sat;
            end
         end
         PH_LENV: begin
            if (nl) begin
               phase_in = PH_HNAME; npos_in = '0; hcand_in = 3'b111;
            end else if (sep) begin
               phase_in = PH_SKIP;
            end else if (32'(tcnt_ff) < MAX_LENGTH_DIGITS && is_digit) begin
               len_in = (len_mul > {4'd0, LEN_MAX}) ? LEN_MAX : len_mul[30:0];
               tcnt_in = tcnt_ff + 8'd1;
            end else begin
               tcnt_in = 8'd255;
            end
         end
         PH_BODY: begin
            if (body_ff < len_ff) begin
               wr_data.tok_vld = 1'b1;
               wr_data.tok_field = FLD_BODY;
               body_in = body_ff + 31'd1;
            end
         end
         default: phase_in = PH_SKIP;
      endcase
      wr_data.tok_byte = in_byte;
      // Both results carry the length after this byte; it only moves on bytes
      // that emit no token.
      wr_data.length = len_in;
      wr_data.sum_vld = in_end;
      wr_data.sum_valid = (phase_in != PH_METHOD) && (mcand_in != 2'b00) && host_in;
      if (in_end) begin
         phase_in = PH_METHOD;
         tcnt_in = '0;
         npos_in = '0;
         hcand_in = 3'b111;
         mcand_in = 2'b11;
         host_in = 1'b0;
         len_in = '0;
         body_in = '0;
         pnl_in = 1'b0;
      end
   end

   assign wr_en = in_vld && (wr_data.tok_vld || in_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_METHOD;
         tcnt_ff <= '0;
         npos_ff <= '0;
         hcand_ff <= 3'b111;
         mcand_ff <= 2'b11;
         host_ff <= 1'b0;
         len_ff <= '0;
         body_ff <= '0;
         pnl_ff <= 1'b0;
      end else if (in_vld) begin
         phase_ff <= phase_in;
         tcnt_ff <= tcnt_in;
         npos_ff <= npos_in;
         hcand_ff <= hcand_in;
         mcand_ff <= mcand_in;
         host_ff <= host_in;
         len_ff <= len_in;
         body_ff <= body_in;
         pnl_ff <= pnl_in;
      end
   end

endmodule

### src/hrhp_queue.sv
// Small FIFO of result groups between the parser and the output stage.
module hrhp_queue
   import hrhp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  work_type wr_data,
   output logic     full,
   output logic     empty,
   input  logic     rd_en,
   output work_type rd_data
);

   work_type   mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;

   assign full = (cnt_ff == 3'd4);
   assign empty = (cnt_ff == 3'd0);
   assign rd_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= wp_ff + 2'd1;
         if (rd_en) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'd0, wr_en} - {2'd0, rd_en};
      end
   end

endmodule

### src/hrhp_back.sv
// Back end: splits each queued group into its results and drives the output register.
module hrhp_back
   import hrhp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     q_empty,
   input  work_type q_data,
   output logic     q_rd,
   output logic     out_vld,
   output rsp_type  out_data,
   input  logic     out_rdy
);

   logic    vld_ff;
   rsp_type data_ff;
   logic    tok_done_ff;
   logic    load, second;
   rsp_type next;

   // The token result of a two-result group goes first.
   assign second = tok_done_ff || !q_data.tok_vld;
   assign load = !q_empty && (!vld_ff || out_rdy);
   assign q_rd = load && (second || !q_data.sum_vld);

   always_comb begin
      if (!second) begin
         next.field = q_data.tok_field;
         next.data = q_data.tok_byte;
         next.length = q_data.length;
         next.valid = 1'b0;
         next.last = !q_data.sum_vld;
      end else begin
         next.field = FLD_SUMMARY;
         next.data = 8'd0;
         next.length = q_data.length;
         next.valid = q_data.sum_valid;
         next.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         tok_done_ff <= 1'b0;
      end else begin
         if (load) vld_ff <= 1'b1;
         else if (out_rdy) vld_ff <= 1'b0;
         if (load) tok_done_ff <= !q_rd;
      end
   end

   assign out_vld = vld_ff;
   assign out_data = data_ff;

endmodule

### src/http_request_header_parser.sv
// Top level of the HTTP request header parser.
// Request bytes enter on the req_ stream, one byte per transfer; req_tlast marks
// the final byte of a request. Results leave on the rsp_ stream: one per kept
// token or body byte, tagged by field in rsp_tuser, and a summary result
// (field 6) after the final byte, carrying the content length and the
// validity flag. rsp_tlast marks the last result caused by one input byte.
// The parser updates its state in the cycle a byte is accepted and writes the
// results into a four-entry queue, from which they are loaded into the output
// register. One byte per cycle is accepted while the queue has room; a byte
// with a token result and the end marker yields two results, which leave the
// output register one after the other while the queue buffers later bytes.
// When the receiver stalls, the queue fills and req_tready falls; nothing is
// dropped. Synchronous reset empties the queue and returns the parser to the
// method phase; after each final byte the parser returns there on its own.
module http_request_header_parser
   import hrhp_pkg::*;
#(
   parameter int unsigned MAX_METHOD_LEN = DefMaxMethodLen,
   parameter int unsigned MAX_URI_LEN = DefMaxUriLen,
   parameter int unsigned MAX_VERSION_LEN = DefMaxVersionLen,
   parameter int unsigned MAX_HOST_LEN = DefMaxHostLen,
   parameter int unsigned MAX_TYPE_LEN = DefMaxTypeLen,
   parameter int unsigned MAX_LENGTH_DIGITS = DefMaxLengthDigits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // req_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_byte [7:0], content_length [38:8], request_valid [39]
   output logic [2:0]  rsp_tuser,   // field_id
   output logic        rsp_tlast
);

   logic     wr_en, full, empty, rd_en;
   work_type wr_data, rd_data;
   rsp_type  out_data;

   assign req_tready = !full;

   hrhp_front #(
      .MAX_METHOD_LEN(MAX_METHOD_LEN),
      .MAX_URI_LEN(MAX_URI_LEN),
      .MAX_VERSION_LEN(MAX_VERSION_LEN),
      .MAX_HOST_LEN(MAX_HOST_LEN),
      .MAX_TYPE_LEN(MAX_TYPE_LEN),
      .MAX_LENGTH_DIGITS(MAX_LENGTH_DIGITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .in_vld(req_tvalid && !full),
      .in_byte(req_tdata),
      .in_end(req_tlast),
      .wr_en(wr_en),
      .wr_data(wr_data)
   );

   hrhp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .wr_en(wr_en),
      .wr_data(wr_data),
      .full(full),
      .empty(empty),
      .rd_en(rd_en),
      .rd_data(rd_data)
   );

   hrhp_back u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(empty),
      .q_data(rd_data),
      .q_rd(rd_en),
      .out_vld(rsp_tvalid),
      .out_data(out_data),
      .out_rdy(rsp_tready)
   );

   assign rsp_tdata = {out_data.valid, out_data.length, out_data.data};
   assign rsp_tuser = out_data.field;
   assign rsp_tlast = out_data.last;

endmodule

### src/hrhp_checker.sv
// Port-level checks of the HTTP request header parser, bound to its top level.
module hrhp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_field_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 3'd7)
      else $error("field code out of range");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == 3'd6 |-> rsp_tlast && rsp_tdata[7:0] == 8'd0)
      else $error("summary result malformed");

   a_valid_only_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != 3'd6 |-> !rsp_tdata[39])
      else $error("validity flag outside summary");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // The queue is empty right after reset, so the input is ready.
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready after reset");

endmodule

bind http_request_header_parser hrhp_checker u_hrhp_checker (
   .clock(clock),
   .reset(reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser),
   .rsp_tlast(rsp_tlast)
);

### tb/tb.sv
// Self-checking testbench for the HTTP request header parser stream block.
module tb;
   import hrhp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned IDLE_LIMIT = 5000;
   localparam int unsigned LONG_STALL = 300;

   typedef struct {
      field_type   fld;
      logic [7:0]  data;
      logic [30:0] len;
      logic        valid;
      logic        last;
   } parse_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   http_request_header_parser DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #10 clock = ~clock;

   // Parser state mirrored by the predictor.
   phase_type   phase;
   int unsigned tok_cnt;
   int unsigned name_pos;
   logic [2:0]  hdr_alive;
   logic [1:0]  meth_alive;
   logic        host_seen;
   logic [30:0] clen;
   logic [30:0] body_cnt;
   logic        prev_nl;

   string hdr_name[3] = '{"Host: ", "Content-Length: ", "Content-Type: "};
   string meth_get = "GET";
   string meth_post = "POST";

   parse_result_type expected_results[$];
   parse_result_type step_results[$];
   int unsigned   fail_count = 0;
   int unsigned   burst_left = 0;
   int unsigned   bytes_sent = 0;
   bit            long_stall_req = 0;
   bit            long_stall_done = 0;

   function automatic void clear_parser();
      phase = PH_METHOD;
      tok_cnt = 0;
      name_pos = 0;
      hdr_alive = 3'b111;
      meth_alive = 2'b11;
      host_seen = 1'b0;
      clen = '0;
      body_cnt = '0;
      prev_nl = 1'b0;
   endfunction

   function automatic void emit(field_type f, logic [7:0] b, logic v);
      parse_result_type r;
      r.fld = f;
      r.data = b;
      r.len = clen;
      r.valid = v;
      r.last = 1'b0;
      step_results.push_back(r);
   endfunction

   function automatic void keep_token(field_type f, logic [7:0] b, int unsigned limit);
      if (tok_cnt < limit) emit(f, b, 1'b0);
      if (tok_cnt < 255) tok_cnt++;
   endfunction

   function automatic void enter_line();
      phase = PH_HNAME;
      name_pos = 0;
      hdr_alive = 3'b111;
   endfunction

   // Advances the mirrored parser by one byte and queues what it yields.
   function automatic void predict_byte(logic [7:0] b, logic last);
      bit sep, nl, done;
      longint v;
      sep = (b == CH_SPACE) || (b == CH_NL);
      nl = (b == CH_NL);
      step_results.delete();
      case (phase)
         PH_METHOD: begin
            if (sep) begin
               if (tok_cnt != 3) meth_alive[0] = 1'b0;
               if (tok_cnt != 4) meth_alive[1] = 1'b0;
               phase = PH_URI;
               tok_cnt = 0;
            end else begin
               if (tok_cnt >= 3 || b != meth_get[tok_cnt]) meth_alive[0] = 1'b0;
               if (tok_cnt >= 4 || b != meth_post[tok_cnt]) meth_alive[1] = 1'b0;
               keep_token(FLD_METHOD, b, DefMaxMethodLen);
            end
         end
         PH_URI: begin
            if (sep) begin
               phase = PH_VERSION;
               tok_cnt = 0;
            end else keep_token(FLD_URI, b, DefMaxUriLen);
         end
         PH_VERSION: begin
            if (nl) enter_line();
            else if (sep) phase = PH_SKIP;
            else keep_token(FLD_VERSION, b, DefMaxVersionLen);
         end
         PH_SKIP: if (nl) enter_line();
         PH_HNAME: begin
            if (nl) begin
               if (name_pos == 0 && prev_nl) begin
                  phase = PH_BODY;
                  body_cnt = '0;
               end else enter_line();
            end else begin
               for (int c = 0; c < 3; c++)
                  if (hdr_alive[c] &&
                      (name_pos >= hdr_name[c].len() || b != hdr_name[c][name_pos]))
                     hdr_alive[c] = 1'b0;
               name_pos++;
               if (hdr_alive == 3'b000) begin
                  phase = PH_SKIP;
                  name_pos = 0;
               end else begin
                  done = 0;
                  for (int c = 0; c < 3; c++) begin
                     if (!done && hdr_alive[c] && hdr_name[c].len() == name_pos) begin
                        done = 1;
                        tok_cnt = 0;
                        name_pos = 0;
                        hdr_alive = 3'b111;
                        if (c == 0) begin
                           phase = PH_HOSTV;
                           host_seen = 1'b1;
                        end else if (c == 1) begin
                           phase = PH_LENV;
                           clen = '0;
                        end else phase = PH_TYPEV;
                     end
                  end
               end
            end
         end
         PH_HOSTV, PH_TYPEV: begin
            if (nl) enter_line();
            else if (sep) phase = PH_SKIP;
            else if (phase == PH_HOSTV) keep_token(FLD_HOST, b, DefMaxHostLen);
            else keep_token(FLD_TYPE, b, DefMaxTypeLen);
         end
         PH_LENV: begin
            if (nl) enter_line();
            else if (sep) phase = PH_SKIP;
            else if (tok_cnt < DefMaxLengthDigits && b >= "0" && b <= "9") begin
               v = longint'(clen) * 10 + longint'(b - 8'h30);
               clen = (v > longint'(LEN_MAX)) ? LEN_MAX : v[30:0];
               tok_cnt++;
            end else tok_cnt = 255;
         end
         PH_BODY: begin
            if (body_cnt < clen) begin
               emit(FLD_BODY, b, 1'b0);
               body_cnt++;
            end
         end
         default: phase = PH_SKIP;
      endcase
      prev_nl = nl;
      if (last) begin
         emit(FLD_SUMMARY, 8'h00,
              phase != PH_METHOD && meth_alive != 2'b00 && host_seen);
         clear_parser();
      end
      if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
      foreach (step_results[i]) expected_results.push_back(step_results[i]);
   endfunction

   // Offers one byte, waits for its transfer, then maybe pauses between bursts.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      predict_byte(b, last);
      bytes_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clock);
         end
      end else burst_left--;
   endtask

   task automatic send_text(input string s, input bit end_here);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], end_here && i == s.len() - 1);
   endtask

   task automatic test_request_line();
      send_text("GET /a HTTP/1.1\nHost: h\n\n", 1);
      send_text("POST /x HTTP/1.0 trailing\nHost: q\n\n", 1);
      send_text("GETX  HTTP/1.1\nHost: z\n", 1);
      send_text("GE", 1);
      send_byte(8'hFF, 1'b1);
      send_text("PUT /\n", 1);
      send_text("GETTINGLONG /u HTTP/1.1.23\nHost: h\n", 1);
   endtask

   task automatic test_headers();
      send_text("POST / HTTP/1.1\nX-Foo: Host: bad\nContent-Type: text/plain extra\n", 0);
      send_text("Content-Length: 3\nContent-Length: 5x9\nHost: one\nHost: two\n\n", 0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("abcdefg", 1);
      send_text("GET / V\nContent-Length: 99999999999\n", 1);
      send_text("GET / V\nContent-Length: 2147483648 \n", 1);
      send_text("GET / V\nContent-Length: 2147483647\nhost: no\n\n", 1);
   endtask

   task automatic test_backpressure();
      long_stall_req = 1;
      send_text("POST /stall HTTP/1.1\nHost: busy.example\nContent-Length: 40\n\n", 0);
      for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(0, 255)), i == 39);
   endtask

   function automatic logic [7:0] token_char();
      return $urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(33, 126));
   endfunction

   task automatic test_random_requests();
      logic [7:0] text[$];
      string      s;
      int unsigned n, blen, cut;
      while (bytes_sent < 1000) begin
         text.delete();
         if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 30);
            repeat (n) text.push_back(8'($urandom_range(0, 255)));
         end else begin
            case ($urandom_range(0, 3))
               0: s = "GET";
               1: s = "POST";
               2: s = "POSTS";
               default: s = "";
            endcase
            for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
            if (s.len() == 0) repeat ($urandom_range(0, 9)) text.push_back(token_char());
            text.push_back(CH_SPACE);
            n = $urandom_range(0, 30) == 0 ? 260 : $urandom_range(0, 12);
            repeat (n) text.push_back(token_char());
            text.push_back(CH_SPACE);
            repeat ($urandom_range(0, 11)) text.push_back(token_char());
            text.push_back($urandom_range(0, 4) == 0 ? CH_SPACE : CH_NL);
            blen = 0;
            repeat ($urandom_range(0, 4)) begin
               case ($urandom_range(0, 4))
                  0: s = "Host: ";
                  1: begin
                     blen = $urandom_range(0, 12);
                     s = $sformatf("Content-Length: %0d", blen);
                  end
                  2: s = "Content-Type: ";
                  3: s = "Content-Len: ";
                  default: s = "Hos";
               endcase
               for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
               repeat ($urandom_range(0, 8)) text.push_back(token_char());
               text.push_back($urandom_range(0, 5) == 0 ? CH_SPACE : CH_NL);
            end
            text.push_back(CH_NL);
            repeat (blen + $urandom_range(0, 3)) text.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 7) == 0) begin
               cut = $urandom_range(1, text.size());
               while (text.size() > cut) void'(text.pop_back());
            end
         end
         foreach (text[i]) send_byte(text[i], i == text.size() - 1);
      end
   endtask

   // Receiver: rotates through four stall habits, plus one long hold-off.
   int unsigned rx_cycle = 0;
   int unsigned stall_left = 0;
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (long_stall_req && !long_stall_done) begin
         long_stall_done <= 1;
         stall_left <= LONG_STALL;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case ((rx_cycle / 64) % 4)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) == 1);
            2: rsp_tready <= (rx_cycle % 3) != 0;
            default: rsp_tready <= $urandom_range(0, 4) == 0;
         endcase
      end
   end

   // Compares every result transfer with the oldest expectation.
   always @(posedge clock) begin
      parse_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result field=%0d data=%h", $time, rsp_tuser,
                     rsp_tdata[7:0]);
            fail_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_tuser != e.fld || rsp_tdata[7:0] != e.data || rsp_tdata[38:8] != e.len
                || rsp_tdata[39] != e.valid || rsp_tlast != e.last) begin
               $display("%0t: mismatch expected field=%0d data=%h len=%0d valid=%b last=%b",
                        $time, e.fld, e.data, e.len, e.valid, e.last);
               $display("%0t:          actual   field=%0d data=%h len=%0d valid=%b last=%b",
                        $time, rsp_tuser, rsp_tdata[7:0], rsp_tdata[38:8], rsp_tdata[39],
                        rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   int unsigned idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      clear_parser();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_request_line();
      test_headers();
      test_backpressure();
      test_random_requests();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
